### design/asd_pkg.sv
package asd_pkg;

  localparam int IN_W            = 16;
  localparam int LEVEL_W         = 20;
  localparam int TIME_W          = 32;
  localparam int COUNT_W         = 32;
  localparam int DEB_W           = 16;
  localparam int CFG_W           = 20;
  localparam int COEF_W          = 16;
  localparam int MIX_W           = LEVEL_W + COEF_W;
  localparam int SAMPLE_BITS_DEF = 16;

  // Smoothing coefficients in Q0.16: alpha = 0.3, and one minus alpha.
  localparam logic [COEF_W-1:0] ALPHA_Q16 = 16'd19661;
  localparam logic [COEF_W-1:0] BETA_Q16  = 16'd45875;
  localparam logic [MIX_W-1:0]  ROUND_HALF = MIX_W'(32768);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  // Alpha times the saturated magnitude.
  localparam logic [MIX_W-1:0] SAT_PROD = MIX_W'(64'(LEVEL_MAX) * 64'(ALPHA_Q16));

  localparam logic [LEVEL_W-1:0] UPPER_THR_RST   = 20'd314573;
  localparam logic [LEVEL_W-1:0] HYST_RST        = 20'd39322;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 16'd250;
  localparam logic [LEVEL_W-1:0] FILT_START_RST  = 20'd262144;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    CFG_UPPER_THR  = 2'd0,
    CFG_HYST       = 2'd1,
    CFG_DEBOUNCE   = 2'd2,
    CFG_FILT_START = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                     operation;
    logic signed [IN_W-1:0]   accel_x;
    logic signed [IN_W-1:0]   accel_y;
    logic signed [IN_W-1:0]   accel_z;
    logic [TIME_W-1:0]        time_ms;
  } asd_in_t;

  typedef struct packed {
    logic                 event_res;
    logic [COUNT_W-1:0]   event_count;
    logic [LEVEL_W-1:0]   filtered_level;
  } asd_out_t;

  // Load and advance controls for the serial datapath units.
  typedef struct packed {
    logic load;
    logic step;
  } step_ctl_t;

  // Controls for a serial constant multiplier fed one bit per cycle while enabled.
  typedef struct packed {
    logic clr;
    logic en;
    logic din;
  } ser_ctl_t;

endpackage

### design/asd_sqsum.sv
module asd_sqsum import asd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  step_ctl_t                ctl,
  input  logic signed [IN_W-1:0]   ax,
  input  logic signed [IN_W-1:0]   ay,
  input  logic signed [IN_W-1:0]   az,
  output logic [2*SAMPLE_BITS+1:0] sum
);

  localparam int SB   = SAMPLE_BITS;
  localparam int SQ_W = 2 * SB + 2;
  localparam int HI_W = SB + 3;

  logic [SB-1:0]   ax_r, ay_r, az_r;
  logic [SB-1:0]   mx_r, my_r, mz_r;
  logic [SQ_W-1:0] p_r;
  logic [HI_W-1:0] pp;
  logic [HI_W-1:0] hi;

  // Magnitude of the sample sign-extended from its low SB bits.
  function automatic logic [SB-1:0] mag_of(input logic [IN_W-1:0] v);
    logic [SB-1:0] raw;
    begin
      raw = SB'(v);
      if (raw[SB-1]) begin
        return ~raw + SB'(1);
      end
      return raw;
    end
  endfunction

  // Three serial-parallel squarers share one accumulator, LSB first.
  always_comb begin
    pp = (mx_r[0] ? HI_W'(ax_r) : '0) + (my_r[0] ? HI_W'(ay_r) : '0)
       + (mz_r[0] ? HI_W'(az_r) : '0);
    hi = HI_W'(p_r[SQ_W-1:SB]) + pp;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ax_r <= mag_of($unsigned(ax));
      ay_r <= mag_of($unsigned(ay));
      az_r <= mag_of($unsigned(az));
      mx_r <= mag_of($unsigned(ax));
      my_r <= mag_of($unsigned(ay));
      mz_r <= mag_of($unsigned(az));
      p_r  <= '0;
    end else if (ctl.step) begin
      mx_r <= mx_r >> 1;
      my_r <= my_r >> 1;
      mz_r <= mz_r >> 1;
      p_r  <= {hi, p_r[SB-1:1]};
    end
  end

  assign sum = p_r;

endmodule

### design/asd_isqrt.sv
module asd_isqrt import asd_pkg::*; #(
  parameter int ROOT_W = SAMPLE_BITS_DEF + 5
) (
  input  logic                  clk,
  input  step_ctl_t             ctl,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output logic                  root_bit
);

  localparam int REM_W = ROOT_W + 1;
  localparam int SH_W  = ROOT_W + 3;

  logic [2*ROOT_W-1:0] n_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SH_W-1:0]     rem_sh;
  logic [SH_W-1:0]     trial;
  logic                ge;

  // One root bit per cycle while stepped, most significant first.
  always_comb begin
    rem_sh   = {rem_r, n_r[2*ROOT_W-1 -: 2]};
    trial    = SH_W'({root_r, 2'b01});
    ge       = rem_sh >= trial;
    root_bit = ge;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.step) begin
      n_r    <= n_r << 2;
      rem_r  <= REM_W'(ge ? rem_sh - trial : rem_sh);
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;

endmodule

### design/asd_cmul.sv
module asd_cmul import asd_pkg::*; #(
  parameter int               ACC_W = MIX_W,
  parameter logic [COEF_W-1:0] K    = ALPHA_Q16
) (
  input  logic              clk,
  input  ser_ctl_t          ctl,
  output logic [ACC_W-1:0]  acc
);

  logic [ACC_W-1:0] acc_r;

  // Multiplier bits arrive most significant first.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= (acc_r << 1) + (ctl.din ? ACC_W'(K) : '0);
    end
  end

  assign acc = acc_r;

endmodule

### design/accel_step_detector_unit.sv
// Accelerometer step counter.
// Input channel: in_valid / in_stall carry one transfer of asd_in_t. A
// sample operation computes the floor square root of the sum of squared
// axes (scaled to Q16.4), smooths it with an exponential average and runs
// the arm / disarm detector with debounce. A clear operation zeroes the
// counter and detector and reloads the level from filter_start.
// Result channel: out_valid / out_stall carry one transfer of asd_out_t
// for every input transfer, in order.
// Configuration: cfg_we writes cfg_wdata into the register named by
// cfg_index on the same edge; write only while the block is idle.
// Sequence: a sample runs the serial squarer, loads and runs the
// bit-serial square root, forms the new level and then runs the detector;
// the squarer and the square root dominate. A clear goes straight to the
// detector. One item is worked on at a time, so the next input transfer
// is taken in the cycle after the result is registered.
// The output register holds a result while the receiver stalls; a new
// item may be taken and worked on meanwhile, and it waits in its final
// step until the register frees.
// Reset loads the register defaults, sets the level to one g, clears the
// count and the detector, and empties the output register.
module accel_step_detector_unit import asd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  asd_in_t            in_data,
  output logic               in_stall,
  output logic               out_valid,
  output asd_out_t           out_data,
  input  logic               out_stall,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int SQ_W   = 2 * SAMPLE_BITS + 2;
  localparam int RAD_W  = SQ_W + 8;
  localparam int ROOT_W = RAD_W / 2;
  localparam int MP_W   = ROOT_W + COEF_W;
  localparam int CMP_W  = (ROOT_W > LEVEL_W) ? ROOT_W : LEVEL_W;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int LPC_W  = $clog2(LEVEL_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_LD,
    ST_RT,
    ST_MIX,
    ST_DET
  } state_t;

  // Configuration registers.
  logic [LEVEL_W-1:0] thr_r;
  logic [LEVEL_W-1:0] hyst_r;
  logic [DEB_W-1:0]   deb_r;
  logic [LEVEL_W-1:0] fstart_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LPC_W-1:0]   lp_cnt_r, lp_cnt_nxt;
  logic [LEVEL_W-1:0] lvl_sh_r, lvl_sh_nxt;
  logic               clr_r, clr_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               deb_ok_r, deb_ok_nxt;
  logic [LEVEL_W-1:0] dis_lvl_r, dis_lvl_nxt;
  logic               dis_en_r, dis_en_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               armed_r, armed_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  asd_out_t           out_data_r, out_data_nxt;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic               ev_nxt;
  logic [SQ_W-1:0]    sq_sum;
  logic [ROOT_W-1:0]  root;
  logic               root_bit;
  logic [MP_W-1:0]    mag_prod;
  logic [MIX_W-1:0]   lvl_prod;
  logic               sat;
  logic [MIX_W-1:0]   mix_sum;
  step_ctl_t          sq_ctl;
  step_ctl_t          rt_ctl;
  ser_ctl_t           mag_ctl;
  ser_ctl_t           lvl_ctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sum of squares, then the square root of that sum scaled by 256.
  assign sq_ctl = '{load: accept, step: (state_r == ST_SQ)};
  assign rt_ctl = '{load: (state_r == ST_LD), step: (state_r == ST_RT)};

  asd_sqsum #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqsum (
    .clk (clk),
    .ctl (sq_ctl),
    .ax  (in_data.accel_x),
    .ay  (in_data.accel_y),
    .az  (in_data.accel_z),
    .sum (sq_sum)
  );

  asd_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
    .clk      (clk),
    .ctl      (rt_ctl),
    .radicand ({sq_sum, 8'd0}),
    .root     (root),
    .root_bit (root_bit)
  );

  // The root bits feed the alpha product as they are decided, while the
  // old level is multiplied by one minus alpha from the moment of the
  // input transfer.
  assign mag_ctl = '{clr: (state_r == ST_LD), en: (state_r == ST_RT), din: root_bit};
  assign lvl_ctl = '{clr: accept, en: (lp_cnt_r != '0), din: lvl_sh_r[LEVEL_W-1]};

  asd_cmul #(.ACC_W(MP_W), .K(ALPHA_Q16)) u_mag_mul (
    .clk (clk),
    .ctl (mag_ctl),
    .acc (mag_prod)
  );

  asd_cmul #(.ACC_W(MIX_W), .K(BETA_Q16)) u_lvl_mul (
    .clk (clk),
    .ctl (lvl_ctl),
    .acc (lvl_prod)
  );

  // A root above the 20-bit range saturates, and so does its product.
  assign sat     = CMP_W'(root) > CMP_W'(LEVEL_MAX);
  assign mix_sum = (sat ? SAT_PROD : MIX_W'(mag_prod)) + lvl_prod + ROUND_HALF;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= UPPER_THR_RST;
      hyst_r   <= HYST_RST;
      deb_r    <= DEBOUNCE_RST;
      fstart_r <= FILT_START_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UPPER_THR:  thr_r    <= cfg_wdata;
        CFG_HYST:       hyst_r   <= cfg_wdata;
        CFG_DEBOUNCE:   deb_r    <= cfg_wdata[DEB_W-1:0];
        CFG_FILT_START: fstart_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lp_cnt_nxt    = lp_cnt_r;
    lvl_sh_nxt    = lvl_sh_r;
    clr_nxt       = clr_r;
    time_nxt      = time_r;
    elapsed_nxt   = elapsed_r;
    deb_ok_nxt    = deb_ok_r;
    dis_lvl_nxt   = dis_lvl_r;
    dis_en_nxt    = dis_en_r;
    level_nxt     = level_r;
    armed_nxt     = armed_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ev_nxt        = 1'b0;
    emit          = 1'b0;

    // The old level is shifted out most significant bit first.
    if (lp_cnt_r != '0) begin
      lp_cnt_nxt = lp_cnt_r - LPC_W'(1);
      lvl_sh_nxt = lvl_sh_r << 1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          clr_nxt    = (in_data.operation == OP_CLEAR);
          time_nxt   = in_data.time_ms;
          lvl_sh_nxt = level_r;
          lp_cnt_nxt = LPC_W'(LEVEL_W);
          cnt_nxt    = CNT_W'(SAMPLE_BITS - 1);
          state_nxt  = (in_data.operation == OP_CLEAR) ? ST_DET : ST_SQ;
        end
      end
      ST_SQ: begin
        // The detector's comparisons are prepared while the squarer runs.
        elapsed_nxt = time_r - last_r;
        deb_ok_nxt  = elapsed_r >= TIME_W'(deb_r);
        dis_lvl_nxt = thr_r - hyst_r;
        dis_en_nxt  = hyst_r <= thr_r;
        if (cnt_r == '0) begin
          state_nxt = ST_LD;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_LD: begin
        cnt_nxt   = CNT_W'(ROOT_W - 1);
        state_nxt = ST_RT;
      end
      ST_RT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_MIX;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_MIX: begin
        level_nxt = mix_sum[MIX_W-1 -: LEVEL_W];
        state_nxt = ST_DET;
      end
      ST_DET: begin
        if (out_free) begin
          emit = 1'b1;
          if (clr_r) begin
            level_nxt = fstart_r;
            armed_nxt = 1'b0;
            last_nxt  = '0;
            count_nxt = '0;
          end else if (level_r > thr_r && !armed_r) begin
            armed_nxt = 1'b1;
          end else if (armed_r && dis_en_r && level_r < dis_lvl_r) begin
            armed_nxt = 1'b0;
            if (deb_ok_r) begin
              count_nxt = count_r + COUNT_W'(1);
              last_nxt  = time_r;
              ev_nxt    = 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{event_res: ev_nxt, event_count: count_nxt,
                            filtered_level: level_nxt};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      lp_cnt_r    <= '0;
      level_r     <= FILT_START_RST;
      armed_r     <= 1'b0;
      last_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lp_cnt_r    <= lp_cnt_nxt;
      level_r     <= level_nxt;
      armed_r     <= armed_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lvl_sh_r   <= lvl_sh_nxt;
    clr_r      <= clr_nxt;
    time_r     <= time_nxt;
    elapsed_r  <= elapsed_nxt;
    deb_ok_r   <= deb_ok_nxt;
    dis_lvl_r  <= dis_lvl_nxt;
    dis_en_r   <= dis_en_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The level product must be complete before the new level is formed.
  a_lvl_prod_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX |-> lp_cnt_r == '0)
    else $error("level product still running at mix");

  // A counted event advances the counter by exactly one.
  a_event_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit && ev_nxt |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("event without count increment");

  // Emitting a result always returns the sequencer to idle and fills the
  // output register.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> state_r == ST_IDLE && out_valid_r)
    else $error("result emitted without returning to idle");

  // The output register is never overwritten while the receiver stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("result overwritten under stall");
`endif

endmodule
